[rtl/sparse_ternary_ball_sampler_defines.svh]
// Assertion macros shared by the checker of the ball sampler.
`ifndef SPARSE_TERNARY_BALL_SAMPLER_DEFINES_SVH
`define SPARSE_TERNARY_BALL_SAMPLER_DEFINES_SVH

// Same-cycle implication, sampled on clk and switched off during reset.
`define STBS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and switched off during reset.
`define STBS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/stbs_pkg.sv]
`timescale 1ns / 1ps

package stbs_pkg;

  localparam int HEADER_BYTES = 8;
  localparam int MAX_WEIGHT = 64;
  localparam logic [6:0] WEIGHT_RESET = 7'd39;

  // Work handed from the control stage to the table stage for one word.
  typedef struct packed {
    logic       clr;    // start of a run: forget every table write
    logic       place;  // accepted candidate: read and swap the table
    logic [7:0] j;      // candidate index taken from the stream
    logic [7:0] r;      // entry at the top of the shrinking range
    logic       neg;    // sign bit for this placement
    logic       last;   // final placement of the run
  } req_t;

  // Result leaving the table stage.
  typedef struct packed {
    logic [7:0] position;
    logic       neg;
    logic       last;
  } res_t;

endpackage

[rtl/stbs_ctrl.sv]
`timescale 1ns / 1ps

module stbs_ctrl #(
  parameter int POLY_LEN = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                acc,
  input  logic [7:0]          stream_byte,
  input  logic                start_req,
  input  logic                weight_we,
  input  logic [6:0]          weight_data,
  output stbs_pkg::req_t      req
);
  import stbs_pkg::*;

  localparam logic [8:0] TOP_IDX = 9'(POLY_LEN - 1);

  logic [63:0] sign_bits, sign_bits_next;
  logic [3:0]  header_count, header_count_next;
  logic [6:0]  placed_count, placed_count_next;
  logic        run_done, run_done_next;
  logic [6:0]  weight;

  logic [63:0] sign_cur;
  logic [3:0]  hc_cur;
  logic [6:0]  pc_cur;
  logic        done_cur;
  logic [6:0]  w_eff;
  logic [7:0]  replace;
  logic        place;
  logic        is_last;

  always_comb begin
    sign_cur = start_req ? '0 : sign_bits;
    hc_cur   = start_req ? '0 : header_count;
    pc_cur   = start_req ? '0 : placed_count;
    done_cur = start_req ? 1'b0 : run_done;
    w_eff    = (weight > 7'(MAX_WEIGHT)) ? 7'(MAX_WEIGHT) : weight;
    replace  = 8'(TOP_IDX - {2'b00, pc_cur});

    sign_bits_next    = sign_cur;
    header_count_next = hc_cur;
    placed_count_next = pc_cur;
    run_done_next     = done_cur;
    place             = 1'b0;
    is_last           = 1'b0;

    if (!done_cur) begin
      if (hc_cur < 4'(HEADER_BYTES)) begin
        sign_bits_next    = {sign_cur[55:0], stream_byte};
        header_count_next = hc_cur + 4'd1;
        if (hc_cur == 4'(HEADER_BYTES - 1) && w_eff == 7'd0) begin
          run_done_next = 1'b1;
        end
      end else if (pc_cur >= w_eff) begin
        run_done_next = 1'b1;
      end else if (stream_byte <= replace) begin
        place             = 1'b1;
        placed_count_next = pc_cur + 7'd1;
        is_last           = (pc_cur + 7'd1) >= w_eff;
        run_done_next     = is_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sign_bits    <= '0;
      header_count <= '0;
      placed_count <= '0;
      run_done     <= 1'b1;
      weight       <= WEIGHT_RESET;
    end else begin
      if (acc) begin
        sign_bits    <= sign_bits_next;
        header_count <= header_count_next;
        placed_count <= placed_count_next;
        run_done     <= run_done_next;
      end
      if (weight_we) begin
        weight <= weight_data;
      end
    end
  end

  always_comb begin
    req.clr   = acc & start_req;
    req.place = acc & place;
    req.j     = stream_byte;
    req.r     = replace;
    // Sign bit i of the placement order sits at bit 63 - i.
    req.neg   = sign_cur[~pc_cur[5:0]];
    req.last  = is_last;
  end

endmodule

[rtl/stbs_table.sv]
`timescale 1ns / 1ps

module stbs_table #(
  parameter int POLY_LEN = 256
) (
  input  logic           clk,
  input  logic           rst,
  input  stbs_pkg::req_t req,
  input  logic           advance,
  output logic           s1_valid,
  output stbs_pkg::res_t res
);
  import stbs_pkg::*;

  localparam int IDX_W = $clog2(POLY_LEN);

  logic [IDX_W-1:0] mem [POLY_LEN];
  logic [IDX_W-1:0] rd_j, rd_r;
  logic [POLY_LEN-1:0] written;

  logic [IDX_W-1:0] s1_j, s1_r;
  logic             s1_neg, s1_last;

  logic             fwd_v;
  logic [IDX_W-1:0] fwd_addr, fwd_data;

  logic [IDX_W-1:0] val_j, val_r;
  logic             wr_en;

  // Only the lower entry needs writing back: the top entry of the range is
  // never read again in this run.
  assign wr_en = s1_valid & advance;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[s1_j] <= val_r;
    end
    if (req.place) begin
      rd_j <= mem[req.j[IDX_W-1:0]];
      rd_r <= mem[req.r[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || req.clr) begin
      written <= '0;
    end else if (wr_en) begin
      written[s1_j] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fwd_v    <= 1'b0;
    end else begin
      if (req.place) begin
        s1_valid <= 1'b1;
        // A write landing on the edge of the read is not seen by that read.
        fwd_v    <= wr_en;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.place) begin
      s1_j     <= req.j[IDX_W-1:0];
      s1_r     <= req.r[IDX_W-1:0];
      s1_neg   <= req.neg;
      s1_last  <= req.last;
      fwd_addr <= s1_j;
      fwd_data <= val_r;
    end
  end

  always_comb begin
    if (fwd_v && fwd_addr == s1_j) begin
      val_j = fwd_data;
    end else begin
      val_j = written[s1_j] ? rd_j : s1_j;
    end
    if (fwd_v && fwd_addr == s1_r) begin
      val_r = fwd_data;
    end else begin
      val_r = written[s1_r] ? rd_r : s1_r;
    end
    res.position = 8'(val_j);
    res.neg      = s1_neg;
    res.last     = s1_last;
  end

endmodule

[rtl/sparse_ternary_ball_sampler.sv]
`timescale 1ns / 1ps
// A placing word accepted at the input goes into the table stage registers
// and then, when the output is not stalled, into the output register.
// Throughput: one stream word per cycle unless stalled, set by the one write
// port of the permutation memory and its two registered read ports.
// Reset (rst, synchronous): control state cleared, weight set to 39, no run
// active; memory contents are left alone and masked by per-entry valid bits.

module sparse_ternary_ball_sampler #(
  parameter int POLY_LEN = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        stream_byte,
  input  logic              start_req,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        position,
  output logic signed [1:0] coefficient,
  output logic              last,
  input  logic              weight_we,
  input  logic [6:0]        weight_data
);
  import stbs_pkg::*;

  // The control stage decides from its own registers and the incoming byte
  // whether a word is a header word, a rejected candidate or a placement,
  // so the next word can be judged in the very next cycle. The table stage
  // holds one placement while its two memory reads return; it writes the
  // swapped entry back as it moves on, and forwards that write to the
  // following placement, whose reads were issued on the same edge.

  req_t req;
  res_t res;
  logic acc;
  logic s1_valid;
  logic advance;

  // The output register can take a new word when it is empty or being read.
  assign advance  = !out_valid || !out_stall;
  // A word is held off only when the table stage is full and cannot move on.
  assign in_stall = s1_valid && !advance;
  assign acc      = in_valid && !in_stall;

  stbs_ctrl #(
    .POLY_LEN(POLY_LEN)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .acc        (acc),
    .stream_byte(stream_byte),
    .start_req  (start_req),
    .weight_we  (weight_we),
    .weight_data(weight_data),
    .req        (req)
  );

  stbs_table #(
    .POLY_LEN(POLY_LEN)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .advance (advance),
    .s1_valid(s1_valid),
    .res     (res)
  );

  // Output register: it parts the table stage from the consumer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      position    <= res.position;
      coefficient <= res.neg ? 2'sb11 : 2'sb01;
      last        <= res.last;
    end
  end

endmodule

[rtl/stbs_checker.sv]
`timescale 1ns / 1ps
`include "sparse_ternary_ball_sampler_defines.svh"

module stbs_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [7:0]        position,
  input logic signed [1:0] coefficient,
  input logic              last
);

  // The input side is only held off while the output is blocked.
  `STBS_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall, "input stalled without cause")

  // A fresh result needs an accepted word that has passed the table stage.
  `STBS_ASSERT_NOW(a_no_invented, $rose(out_valid), $past(in_valid && !in_stall, 2), "result without input")

  // Only plus one or minus one is ever placed.
  `STBS_ASSERT_NOW(a_coef_code, out_valid, coefficient == 2'sb01 || coefficient == 2'sb11, "bad coefficient")

  // A stalled result holds still.
  `STBS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(position) && $stable(coefficient) && $stable(last), "stalled result changed")

endmodule

bind sparse_ternary_ball_sampler stbs_checker u_stbs_checker (.*);

[tb/sparse_ternary_ball_sampler_tb.sv]
`timescale 1ns / 1ps

module sparse_ternary_ball_sampler_tb;
  import stbs_pkg::*;

  localparam int POLY_LEN = 256;
  // The block loads a placing word's result into its output register through
  // the table stage register, so DRAIN_CYCLES quiet edges after the last
  // result are ample before a weight write.
  localparam int DRAIN_CYCLES = 4;
  // A single long hold-off on the output side, long enough to back the block
  // up and push the stall through to the input.
  localparam int HOLD_CYCLES = 250;
  // Cycles with no word moving on either side before the run is declared hung.
  localparam int QUIET_LIMIT = 5000;

  // Coefficient codes as they appear on the two-bit signed output.
  localparam logic signed [1:0] COEF_PLUS  = 2'sb01;
  localparam logic signed [1:0] COEF_MINUS = 2'sb11;

  typedef struct packed {
    logic [7:0]        position;
    logic signed [1:0] coefficient;
    logic              last;
  } placement_t;

  // Keeps its own copy of the permutation table, sign bits and counters, and
  // the placements that the accepted words are due to produce, oldest first.
  class placement_tracker;
    logic [7:0]  perm [POLY_LEN];
    bit          written [POLY_LEN];
    logic [63:0] signs;
    int unsigned hdr_cnt;
    int unsigned placed;
    bit          run_done;
    logic [6:0]  weight;
    placement_t  pending_placements [$];
    int unsigned errors;

    function new();
      foreach (written[k]) written[k] = 1'b0;
      signs    = '0;
      hdr_cnt  = 0;
      placed   = 0;
      run_done = 1'b1;
      weight   = WEIGHT_RESET;
      errors   = 0;
    endfunction

    function void set_weight(logic [6:0] w);
      weight = w;
    endfunction

    function logic [7:0] entry(int unsigned idx);
      return written[idx] ? perm[idx] : idx[7:0];
    endfunction

    // Returns 1 when the word does something, 0 when the block ignores it.
    function bit note_word(logic [7:0] b, logic s);
      int unsigned eff;
      int unsigned top;
      logic [7:0]  pick;
      placement_t  due;
      if (s) begin
        foreach (written[k]) written[k] = 1'b0;
        signs    = '0;
        hdr_cnt  = 0;
        placed   = 0;
        run_done = 1'b0;
      end
      if (run_done) return 1'b0;
      eff = (weight > MAX_WEIGHT) ? MAX_WEIGHT : weight;
      if (hdr_cnt < HEADER_BYTES) begin
        signs = {signs[55:0], b};
        hdr_cnt++;
        if (hdr_cnt == HEADER_BYTES && eff == 0) run_done = 1'b1;
        return 1'b1;
      end
      if (placed >= eff) begin
        run_done = 1'b1;
        return 1'b1;
      end
      top = (POLY_LEN - 1 - placed) & 8'hFF;
      if (b > top) return 1'b1;
      pick = entry(b);
      perm[b] = entry(top);
      written[b] = 1'b1;
      perm[top] = pick;
      written[top] = 1'b1;
      due.position    = pick;
      due.coefficient = signs[63 - placed] ? COEF_MINUS : COEF_PLUS;
      placed++;
      due.last = (placed >= eff);
      if (due.last) run_done = 1'b1;
      pending_placements.push_back(due);
      return 1'b1;
    endfunction

    function void check_result(logic [7:0] pos, logic signed [1:0] coef, logic lst);
      placement_t due;
      if (pending_placements.size() == 0) begin
        $error("unexpected placement: position %0d coefficient %0d last %0b",
               pos, coef, lst);
        errors++;
        return;
      end
      due = pending_placements.pop_front();
      if (pos !== due.position) begin
        $error("position: expected %0d, actual %0d", due.position, pos);
        errors++;
      end
      if (coef !== due.coefficient) begin
        $error("coefficient: expected %0d, actual %0d", due.coefficient, coef);
        errors++;
      end
      if (lst !== due.last) begin
        $error("last: expected %0b, actual %0b", due.last, lst);
        errors++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [7:0]        stream_byte = 8'h00;
  logic              start_req = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [7:0]        position;
  logic signed [1:0] coefficient;
  logic              last;
  logic              weight_we = 1'b0;
  logic [6:0]        weight_data = 7'd0;

  placement_tracker tracker;

  // Idle rates in percent; changed only while no word is in flight.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  logic        hold_req = 1'b0;
  logic        hold_served = 1'b0;
  int unsigned hold_left = 0;
  int unsigned quiet = 0;

  sparse_ternary_ball_sampler #(
    .POLY_LEN(POLY_LEN)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .stream_byte(stream_byte),
    .start_req(start_req),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .position(position),
    .coefficient(coefficient),
    .last(last),
    .weight_we(weight_we),
    .weight_data(weight_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Output side. Every word taken off the output is checked against the
  // oldest outstanding placement. The stall is normally random, but once a
  // hold has been asked for it stays high for a long stretch, counted here,
  // so that the block fills and has to stall its input.
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall == 1'b0)
      tracker.check_result(position, coefficient, last);
    if (hold_req && !hold_served) begin
      hold_left   <= HOLD_CYCLES;
      hold_served <= 1'b1;
      out_stall   <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog: a long run of cycles in which no word moves on either side
  // means the block has hung.
  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Offers one word, possibly after idling at random first, and returns once the
  // block has taken it. The tracker learns of the word at that same edge.
  task automatic send_word(input logic [7:0] b, input logic s, output bit consumed);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    stream_byte <= b;
    start_req   <= s;
    do @(posedge clk); while (in_stall !== 1'b0);
    consumed = tracker.note_word(b, s);
  endtask

  // Stops sending, lets every outstanding placement arrive, allows for a
  // word that is still inside the block without a result, then writes the
  // weight. The write may land in the middle of a run, where it takes
  // effect at once.
  task automatic write_weight(input logic [6:0] w);
    in_valid <= 1'b0;
    while (tracker.pending_placements.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    weight_we   <= 1'b1;
    weight_data <= w;
    @(posedge clk);
    weight_we <= 1'b0;
    tracker.set_weight(w);
  endtask

  // Random stream. When no run is active a start is very likely, so most
  // words belong to well-formed runs with random header and candidate bytes;
  // now and then a start arrives mid-run and abandons it. Only words that
  // the block acts on count towards the goal.
  task automatic random_words(input int unsigned goal);
    int unsigned acted;
    logic        s;
    logic [7:0]  b;
    bit          consumed;
    acted = 0;
    while (acted < goal) begin
      if (tracker.run_done)
        s = ($urandom_range(99) < 85);
      else
        s = ($urandom_range(999) < 5);
      b = $urandom_range(255);
      send_word(b, s, consumed);
      if (consumed) acted++;
    end
  endtask

  initial begin
    bit taken;
    tracker = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // First phase: the sender idles now and then, the receiver mostly stalls.
    send_idle_pct  = 13;
    recv_stall_pct = 75;

    // A single placement: a word before any start is ignored, the header
    // opens with a set bit so the sign is negative, and the candidate sits
    // at the very top of the range. The word after the run is ignored too.
    write_weight(7'd1);
    send_word(8'hAB, 1'b0, taken);
    send_word(8'hFF, 1'b1, taken);
    repeat (7) send_word(8'h00, 1'b0, taken);
    send_word(8'hFF, 1'b0, taken);
    send_word(8'h10, 1'b0, taken);

    // Two placements after a restart straight after the first header word.
    // The second top-valued candidate is out of range and rejected.
    write_weight(7'd2);
    send_word(8'h12, 1'b1, taken);
    send_word(8'h80, 1'b1, taken);
    repeat (7) send_word(8'h00, 1'b0, taken);
    send_word(8'hFF, 1'b0, taken);
    send_word(8'hFF, 1'b0, taken);
    send_word(8'h00, 1'b0, taken);

    // A weight of zero: the run ends quietly once the header is complete.
    write_weight(7'd0);
    send_word(8'h5A, 1'b1, taken);
    repeat (7) send_word(8'hFF, 1'b0, taken);
    send_word(8'h00, 1'b0, taken);

    // All weight bits set: clamped to the full 64 placements.
    write_weight(7'd127);
    random_words(70);
    write_weight(7'd1);
    random_words(50);

    // Second phase: the sender idles a lot, the receiver seldom stalls.
    write_weight(7'($urandom_range(63, 2)));
    send_idle_pct  = 75;
    recv_stall_pct = 13;
    random_words(70);
    write_weight(7'd64);
    random_words(70);

    // Last phase: neither side idles, apart from one long hold-off by the
    // receiver while words keep being offered.
    write_weight(WEIGHT_RESET);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req <= 1'b1;
    random_words(80);
    write_weight(7'($urandom_range(127)));
    random_words(60);

    in_valid <= 1'b0;
    while (tracker.pending_placements.size() != 0) @(posedge clk);
    repeat (4 * DRAIN_CYCLES) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending_placements.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
